/* rtl/plr_pkg.sv */
// Shared types and constants of the priority label reduction block.
package plr_pkg;

   localparam logic [7:0] NO_LAYER = 8'hFF;
   localparam logic [7:0] TABLE_RESET = 8'hFF;
   localparam logic [4:0] DEC_MAX = 5'd16;
   localparam int CX_W = 10;
   localparam int COORD_W = 12;
   localparam int XY_W = 7;

   typedef enum logic [1:0] {
      CMD_PIXEL    = 2'd0,
      CMD_PRIORITY = 2'd1,
      CMD_LABEL    = 2'd2,
      CMD_QUERY    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DECIMATION = 2'd0,
      CSR_BOX_RADIUS = 2'd1,
      CSR_WIDTH      = 2'd2,
      CSR_HEIGHT     = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CENTRE,
      ST_CWAIT,
      ST_WIN,
      ST_DRAIN,
      ST_MWAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [4:0] dec;
      logic [3:0] rad;
      logic [6:0] w;
      logic [6:0] h;
   } cfg_type;

   typedef struct packed {
      logic       en;
      logic [7:0] index;
      logic [7:0] data;
   } tbl_wr_type;

endpackage

/* rtl/plr_frame_store.sv */
// Label frame store: one write port, one registered read port.
module plr_frame_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/plr_table.sv */
// 256-entry lookup table with valid bits; unwritten entries read as 255.
module plr_table (
   input  logic                clock,
   input  logic                reset,
   input  plr_pkg::tbl_wr_type wr,
   input  logic [7:0]          rd_addr,
   output logic [7:0]          rd_data
);

   logic [7:0] mem [256];
   logic [255:0] vld_ff;
   logic [7:0] rd_data_ff;
   logic       rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.index] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.index] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : plr_pkg::TABLE_RESET;

endmodule

/* rtl/plr_seq.sv */
// Query sequencer: window walk, shared clamp and address unit, priority reduction.
module plr_seq #(
   parameter int MAX_WIDTH = 64,
   parameter int ADDR_W    = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [5:0]           req_col,
   input  logic [5:0]           req_row,
   input  plr_pkg::cfg_type     cfg,
   input  logic [7:0]           cap,
   output logic [ADDR_W-1:0]    frame_rd_addr,
   input  logic [7:0]           frame_q,
   input  logic [7:0]           prio_q,
   output logic [7:0]           lop_rd_addr,
   input  logic [7:0]           lop_q,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_label,
   output logic                 rsp_valid_res
);

   plr_pkg::state_type state_ff, state_in;
   logic [5:0]  col_ff, col_in, row_ff, row_in;
   logic [plr_pkg::CX_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [4:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [7:0]  centre_ff, centre_in;
   logic [7:0]  acc_ff, acc_in;
   logic        diff_ff, diff_in;
   logic        b_v_ff, b_v_in, c_v_ff, c_v_in, c_ne_ff, c_ne_in;
   logic        le_ff, le_in;
   logic [7:0]  res_label_ff, res_label_in;
   logic        res_vres_ff, res_vres_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_label_ff, rsp_label_in;
   logic        rsp_vres_ff, rsp_vres_in;

   logic [10:0] prod_x, prod_y;
   logic signed [4:0] rad_s, neg_rad, off_x, off_y;
   logic signed [plr_pkg::COORD_W-1:0] xs, ys, wm1_s, hm1_s;
   logic [plr_pkg::XY_W-1:0] xc, yc;
   logic [7:0]  fin;
   logic        outside;

   assign prod_x  = {5'd0, col_ff} * {6'd0, cfg.dec};
   assign prod_y  = {5'd0, row_ff} * {6'd0, cfg.dec};
   assign rad_s   = {1'b0, cfg.rad};
   assign neg_rad = 5'(5'sd0 - rad_s);
   assign outside = ({1'b0, cx_ff} + {6'd0, cfg.dec} > {4'd0, cfg.w})
                 || ({1'b0, cy_ff} + {6'd0, cfg.dec} > {4'd0, cfg.h});

   // shared clamp and address unit
   assign xs    = $signed({2'b00, cx_ff}) + {{(plr_pkg::COORD_W-5){off_x[4]}}, off_x};
   assign ys    = $signed({2'b00, cy_ff}) + {{(plr_pkg::COORD_W-5){off_y[4]}}, off_y};
   assign wm1_s = $signed({5'd0, 7'(cfg.w - 7'd1)});
   assign hm1_s = $signed({5'd0, 7'(cfg.h - 7'd1)});

   always_comb begin
      if (xs < 0) begin
         xc = '0;
      end else if (xs > wm1_s) begin
         xc = wm1_s[plr_pkg::XY_W-1:0];
      end else begin
         xc = xs[plr_pkg::XY_W-1:0];
      end
      if (ys < 0) begin
         yc = '0;
      end else if (ys > hm1_s) begin
         yc = hm1_s[plr_pkg::XY_W-1:0];
      end else begin
         yc = ys[plr_pkg::XY_W-1:0];
      end
   end

   assign frame_rd_addr = ADDR_W'(32'(yc) * MAX_WIDTH + 32'(xc));
   assign fin           = (diff_ff && (cap < acc_ff)) ? cap : acc_ff;
   assign lop_rd_addr   = fin;
   assign req_ready     = (state_ff == plr_pkg::ST_IDLE) && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plr_pkg::ST_IDLE;
         b_v_ff       <= 1'b0;
         c_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_v_ff       <= b_v_in;
         c_v_ff       <= c_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      centre_ff    <= centre_in;
      acc_ff       <= acc_in;
      diff_ff      <= diff_in;
      c_ne_ff      <= c_ne_in;
      le_ff        <= le_in;
      res_label_ff <= res_label_in;
      res_vres_ff  <= res_vres_in;
      rsp_label_ff <= rsp_label_in;
      rsp_vres_ff  <= rsp_vres_in;
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      centre_in    = centre_ff;
      b_v_in       = 1'b0;
      c_v_in       = b_v_ff;
      c_ne_in      = (frame_q != centre_ff);
      acc_in       = (c_v_ff && (prio_q < acc_ff)) ? prio_q : acc_ff;
      diff_in      = diff_ff | (c_v_ff & c_ne_ff);
      le_in        = le_ff;
      res_label_in = res_label_ff;
      res_vres_in  = res_vres_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_label_in = rsp_label_ff;
      rsp_vres_in  = rsp_vres_ff;
      off_x        = '0;
      off_y        = '0;
      unique case (state_ff)
         plr_pkg::ST_IDLE: begin
            if (req_valid && req_ready && (req_command == plr_pkg::CMD_QUERY)) begin
               col_in   = req_col;
               row_in   = req_row;
               state_in = plr_pkg::ST_SETUP;
            end
         end
         plr_pkg::ST_SETUP: begin
            cx_in    = prod_x[plr_pkg::CX_W-1:0];
            cy_in    = prod_y[plr_pkg::CX_W-1:0];
            state_in = plr_pkg::ST_CENTRE;
         end
         plr_pkg::ST_CENTRE: begin
            if (outside) begin
               res_label_in = '0;
               res_vres_in  = 1'b0;
               state_in     = plr_pkg::ST_DONE;
            end else begin
               dx_in    = neg_rad;
               dy_in    = neg_rad;
               state_in = plr_pkg::ST_CWAIT;
            end
         end
         plr_pkg::ST_CWAIT: begin
            centre_in = frame_q;
            acc_in    = plr_pkg::TABLE_RESET;
            diff_in   = 1'b0;
            if ((cfg.dec == 5'd1) && (cfg.rad == 4'd0)) begin
               res_label_in = frame_q;
               res_vres_in  = 1'b1;
               state_in     = plr_pkg::ST_DONE;
            end else begin
               state_in = plr_pkg::ST_WIN;
            end
         end
         plr_pkg::ST_WIN: begin
            off_x  = dx_ff;
            off_y  = dy_ff;
            b_v_in = 1'b1;
            if (dy_ff == rad_s) begin
               dy_in = neg_rad;
               dx_in = 5'(dx_ff + 5'sd1);
               if (dx_ff == rad_s) begin
                  state_in = plr_pkg::ST_DRAIN;
               end
            end else begin
               dy_in = 5'(dy_ff + 5'sd1);
            end
         end
         plr_pkg::ST_DRAIN: begin
            if (!b_v_ff && !c_v_ff) begin
               le_in    = (fin <= cap);
               state_in = plr_pkg::ST_MWAIT;
            end
         end
         plr_pkg::ST_MWAIT: begin
            res_label_in = le_ff ? lop_q : centre_ff;
            res_vres_in  = 1'b1;
            state_in     = plr_pkg::ST_DONE;
         end
         plr_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_label_in = res_label_ff;
               rsp_vres_in  = res_vres_ff;
               state_in     = plr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plr_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_label     = rsp_label_ff;
   assign rsp_valid_res = rsp_vres_ff;

endmodule

/* rtl/priority_label_reduction.sv */
// Priority label reduction top level: command decode, registers, stores, sequencer.
//
// Usage: words arrive on the req_ channel with valid/ready. A pixel write or a
// table write yields no result word. A query yields one word on the rsp_
// channel: the reduced label and valid_res.
// Registers are written on the csr_ channel (index, data), always ready out
// of reset; the user must write them only while the block is idle, as the block does not enforce it.
// Sequence: a query with box radius r passes SETUP, CENTRE and CWAIT, walks the
// (2r+1)^2 window in WIN, then passes DRAIN and MWAIT and reaches DONE;
// the identity setting goes from CWAIT to DONE and a query outside the image
// from CENTRE to DONE. The window walk reads one frame-store pixel per cycle
// through one clamp and address unit. req_ready is low while a query is in
// progress, so the next word waits until the result has left the sequencer.
// Reset: registers take decimation 1, radius 0, width and height 64; both
// tables read 255 until written; the frame store holds no defined content
// until written.
// Stall: a finished result is held in the output register until rsp_ready;
// the block accepts further words meanwhile, and a second query result
// waits in the sequencer until the output register is free.
module priority_label_reduction #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [5:0] req_col,
   input  logic [5:0] req_row,
   input  logic [7:0] req_table_index,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_label,
   output logic       rsp_valid_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [4:0] decimation_ff;
   logic [3:0] box_radius_ff;
   logic [6:0] width_ff, height_ff;
   logic [7:0] cap_ff;
   plr_pkg::cfg_type   cfg;
   plr_pkg::tbl_wr_type prio_wr, lop_wr;
   logic              req_fire;
   logic              fs_wr_en;
   logic [ADDR_W-1:0] fs_wr_addr, fs_rd_addr;
   logic [7:0]        frame_q, prio_q, lop_q, lop_rd_addr;

   assign csr_ready = !reset;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff <= 5'd1;
         box_radius_ff <= 4'd0;
         width_ff      <= 7'd64;
         height_ff     <= 7'd64;
         cap_ff        <= plr_pkg::TABLE_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (plr_pkg::csr_index_type'(csr_index))
               plr_pkg::CSR_DECIMATION: decimation_ff <= csr_data[4:0];
               plr_pkg::CSR_BOX_RADIUS: box_radius_ff <= csr_data[3:0];
               plr_pkg::CSR_WIDTH:      width_ff      <= csr_data[6:0];
               plr_pkg::CSR_HEIGHT:     height_ff     <= csr_data[6:0];
               default: ;
            endcase
         end
         if (prio_wr.en && (prio_wr.index == plr_pkg::NO_LAYER)) begin
            cap_ff <= prio_wr.data;
         end
      end
   end

   always_comb begin
      if (decimation_ff == 5'd0) begin
         cfg.dec = 5'd1;
      end else if (decimation_ff > plr_pkg::DEC_MAX) begin
         cfg.dec = plr_pkg::DEC_MAX;
      end else begin
         cfg.dec = decimation_ff;
      end
      cfg.rad = box_radius_ff;
      if (width_ff == 7'd0) begin
         cfg.w = 7'd1;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         cfg.w = 7'(MAX_WIDTH);
      end else begin
         cfg.w = width_ff;
      end
      if (height_ff == 7'd0) begin
         cfg.h = 7'd1;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         cfg.h = 7'(MAX_HEIGHT);
      end else begin
         cfg.h = height_ff;
      end
   end

   assign fs_wr_en   = req_fire && (req_command == plr_pkg::CMD_PIXEL)
                    && (32'(req_col) < MAX_WIDTH) && (32'(req_row) < MAX_HEIGHT);
   assign fs_wr_addr = ADDR_W'(32'(req_row) * MAX_WIDTH + 32'(req_col));

   assign prio_wr.en    = req_fire && (req_command == plr_pkg::CMD_PRIORITY);
   assign prio_wr.index = req_table_index;
   assign prio_wr.data  = req_value;
   assign lop_wr.en     = req_fire && (req_command == plr_pkg::CMD_LABEL);
   assign lop_wr.index  = req_table_index;
   assign lop_wr.data   = req_value;

   plr_frame_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (fs_wr_en),
      .wr_addr (fs_wr_addr),
      .wr_data (req_value),
      .rd_addr (fs_rd_addr),
      .rd_data (frame_q)
   );

   plr_table u_prio_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (prio_wr),
      .rd_addr (frame_q),
      .rd_data (prio_q)
   );

   plr_table u_lop_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (lop_wr),
      .rd_addr (lop_rd_addr),
      .rd_data (lop_q)
   );

   plr_seq #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_col       (req_col),
      .req_row       (req_row),
      .cfg           (cfg),
      .cap           (cap_ff),
      .frame_rd_addr (fs_rd_addr),
      .frame_q       (frame_q),
      .prio_q        (prio_q),
      .lop_rd_addr   (lop_rd_addr),
      .lop_q         (lop_q),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_label     (rsp_label),
      .rsp_valid_res (rsp_valid_res)
   );

endmodule
